### rtl/fdcm_pkg.sv
// ----------------------------------------------------------------------------
// fdcm_pkg
// Shared types and constants for the frame difference change mask block.
// ----------------------------------------------------------------------------
package fdcm_pkg;

	// default sizes
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int MAX_DELAY_DEF    = 4096;

	// register widths
	localparam int THR_W  = 16;
	localparam int BLEN_W = 21;
	localparam int DLY_W  = 13;
	localparam int POS_W  = 20;
	localparam int CFG_W  = 21;
	localparam int IDX_W  = 2;

	// longest block; larger settings saturate here
	localparam logic [BLEN_W-1:0] BLOCK_LIMIT = 21'd1048576;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_NOISE_THRESHOLD = 2'd0,
		REG_BLOCK_LENGTH    = 2'd1,
		REG_DELAY_LENGTH    = 2'd2
	} reg_idx_t;

	// control carried by the pipeline stage between lookup and compare
	typedef struct packed {
		logic valid;
		logic cmp;
	} ctl_t;

endpackage

### rtl/frame_difference_change_mask.sv
// ----------------------------------------------------------------------------
// frame_difference_change_mask
// Flags samples that differ from the sample delay_length earlier in the same
// block by more than the noise threshold.
//
//  channel  dir  transaction contents
//  s_*      in   tdata: sample; tuser: first_sample
//  m_*      out  tdata: changed, compared
//  cfg_*    in   register write (index, data), no handshake
//
// One sample per clock while the output is not stalled; an accepted sample
// reaches the output through stage 1 and the history read register, then the
// output register.
// The history memory's registered read places the compare after stage 1.
// Reset clears position, pointer and pipeline valids; the history memory is
// not cleared, since no entry is read before it was written.
// A stalled output holds the pipeline; input stays ready while a stage is free.
// ----------------------------------------------------------------------------
module frame_difference_change_mask #(
	parameter int SAMPLE_WIDTH = fdcm_pkg::SAMPLE_WIDTH_DEF,
	parameter int MAX_DELAY    = fdcm_pkg::MAX_DELAY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // [SAMPLE_WIDTH-1:0] sample
	input  logic                              s_tuser,  // [0] first_sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // [0] changed, [1] compared
	input  logic                              cfg_we,
	input  logic [fdcm_pkg::IDX_W-1:0]        cfg_index,
	input  logic [fdcm_pkg::CFG_W-1:0]        cfg_data
);
	import fdcm_pkg::*;

	localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

	logic [THR_W-1:0]        noise_threshold_q;
	logic [BLEN_W-1:0]       block_length_q;
	logic [DLY_W-1:0]        delay_length_q;

	ctl_t                    ctl_s1;
	logic [SAMPLE_WIDTH-1:0] sample_s1;
	logic                    down_ready;
	logic                    st_we;
	logic [AW-1:0]           st_waddr;
	logic                    st_re;
	logic [AW-1:0]           st_raddr;
	logic [SAMPLE_WIDTH-1:0] st_rdata;
	logic                    changed;
	logic                    compared;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_threshold_q <= '0;
			block_length_q    <= BLEN_W'(2);
			delay_length_q    <= DLY_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NOISE_THRESHOLD: noise_threshold_q <= cfg_data[THR_W-1:0];
				REG_BLOCK_LENGTH:    block_length_q    <= cfg_data[BLEN_W-1:0];
				REG_DELAY_LENGTH:    delay_length_q    <= cfg_data[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	fdcm_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.MAX_DELAY    (MAX_DELAY),
		.AW           (AW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.sample       (s_tdata[SAMPLE_WIDTH-1:0]),
		.first_sample (s_tuser),
		.block_length (block_length_q),
		.delay_length (delay_length_q),
		.down_ready   (down_ready),
		.ctl_s1       (ctl_s1),
		.sample_s1    (sample_s1),
		.st_we        (st_we),
		.st_waddr     (st_waddr),
		.st_re        (st_re),
		.st_raddr     (st_raddr)
	);

	fdcm_store #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.MAX_DELAY    (MAX_DELAY),
		.AW           (AW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (s_tdata[SAMPLE_WIDTH-1:0]),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	fdcm_cmp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_cmp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl_s1          (ctl_s1),
		.sample_s1       (sample_s1),
		.rd_data         (st_rdata),
		.noise_threshold (noise_threshold_q),
		.down_ready      (down_ready),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.changed         (changed),
		.compared        (compared)
	);

	assign m_tdata = {6'b0, compared, changed};

	// a change is only reported for a compared sample
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
		else $error("changed set without compared");

	// input backpressure only when both stages are full and output stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (ctl_s1.valid && m_tvalid && !m_tready))
		else $error("input stalled with a free stage");

	// an accepted sample lands in stage 1 on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> ctl_s1.valid)
		else $error("accepted sample lost before stage 1");

	// every accepted sample writes the history memory
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> st_we)
		else $error("accepted sample not written to history");

endmodule

### rtl/fdcm_store.sv
// ----------------------------------------------------------------------------
// fdcm_store
// Delay history memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fdcm_store #(
	parameter int SAMPLE_WIDTH = fdcm_pkg::SAMPLE_WIDTH_DEF,
	parameter int MAX_DELAY    = fdcm_pkg::MAX_DELAY_DEF,
	parameter int AW           = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [SAMPLE_WIDTH-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic [SAMPLE_WIDTH-1:0] rdata
);
	import fdcm_pkg::*;

	logic [SAMPLE_WIDTH-1:0] mem [MAX_DELAY];
	logic [SAMPLE_WIDTH-1:0] rdata_q;

	// read-before-write: a read of the entry being written returns the old value
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/fdcm_front.sv
// ----------------------------------------------------------------------------
// fdcm_front
// Input stage: block position, store pointer, compare decision and store
// addressing for each accepted sample.
// ----------------------------------------------------------------------------
module fdcm_front #(
	parameter int SAMPLE_WIDTH = fdcm_pkg::SAMPLE_WIDTH_DEF,
	parameter int MAX_DELAY    = fdcm_pkg::MAX_DELAY_DEF,
	parameter int AW           = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [SAMPLE_WIDTH-1:0]       sample,
	input  logic                          first_sample,
	input  logic [fdcm_pkg::BLEN_W-1:0]   block_length,
	input  logic [fdcm_pkg::DLY_W-1:0]    delay_length,
	input  logic                          down_ready,
	output fdcm_pkg::ctl_t                ctl_s1,
	output logic [SAMPLE_WIDTH-1:0]       sample_s1,
	output logic                          st_we,
	output logic [AW-1:0]                 st_waddr,
	output logic                          st_re,
	output logic [AW-1:0]                 st_raddr
);
	import fdcm_pkg::*;

	localparam int CW = ((AW > DLY_W) ? AW : DLY_W) + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(MAX_DELAY);
	localparam logic [AW-1:0] LAST_A  = AW'(MAX_DELAY - 1);

	logic [POS_W-1:0]  pos_q;
	logic [AW-1:0]     ptr_q;
	logic              valid_s1;
	logic              cmp_s1;

	logic              accept;
	logic [BLEN_W-1:0] blen;
	logic [POS_W-1:0]  pos_eff;
	logic [BLEN_W-1:0] pos_nxt;
	logic              key_ok;
	logic              cmp;
	logic [CW-1:0]     ptr_c;
	logic [CW-1:0]     dly_c;
	logic [CW-1:0]     raddr_c;

	assign s_tready = !valid_s1 || down_ready;
	assign accept   = s_tvalid && s_tready;

	// position and compare decision
	always_comb begin
		blen    = (block_length > BLOCK_LIMIT) ? BLOCK_LIMIT : block_length;
		pos_eff = (first_sample || (BLEN_W'(pos_q) >= blen)) ? '0 : pos_q;
		key_ok  = (delay_length != '0) && (BLEN_W'(delay_length) < blen)
			&& (CW'(delay_length) <= DEPTH_C);
		cmp     = key_ok && (BLEN_W'(pos_eff) >= BLEN_W'(delay_length));
		pos_nxt = BLEN_W'(pos_eff) + BLEN_W'(1);
		if (pos_nxt >= blen) begin
			pos_nxt = '0;
		end
	end

	// circular read address, delay_length entries behind the write pointer
	always_comb begin
		ptr_c = CW'(ptr_q);
		dly_c = CW'(delay_length);
		if (ptr_c >= dly_c) begin
			raddr_c = ptr_c - dly_c;
		end else begin
			raddr_c = ptr_c + DEPTH_C - dly_c;
		end
	end

	assign st_we    = accept;
	assign st_waddr = ptr_q;
	assign st_re    = accept && cmp;
	assign st_raddr = raddr_c[AW-1:0];

	// position and pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ptr_q <= '0;
		end else if (accept) begin
			pos_q <= pos_nxt[POS_W-1:0];
			ptr_q <= (ptr_q == LAST_A) ? '0 : ptr_q + AW'(1);
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (down_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmp_s1    <= cmp;
			sample_s1 <= sample;
		end
	end

	// fields in declaration order: valid, cmp
	assign ctl_s1 = {valid_s1, cmp_s1};

endmodule

### rtl/fdcm_cmp.sv
// ----------------------------------------------------------------------------
// fdcm_cmp
// Absolute difference against the delayed sample, threshold test and the
// output register.
// ----------------------------------------------------------------------------
module fdcm_cmp #(
	parameter int SAMPLE_WIDTH = fdcm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fdcm_pkg::ctl_t              ctl_s1,
	input  logic [SAMPLE_WIDTH-1:0]     sample_s1,
	input  logic [SAMPLE_WIDTH-1:0]     rd_data,
	input  logic [fdcm_pkg::THR_W-1:0]  noise_threshold,
	output logic                        down_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        changed,
	output logic                        compared
);
	import fdcm_pkg::*;

	localparam int DW = SAMPLE_WIDTH + 1;
	localparam int MW = (DW > THR_W) ? DW : THR_W;

	logic          valid_q;
	logic          changed_q;
	logic          compared_q;
	logic [DW-1:0] diff;
	logic [DW-1:0] absd;
	logic          over;

	// signed difference, magnitude and threshold test
	always_comb begin
		diff = {sample_s1[SAMPLE_WIDTH-1], sample_s1} - {rd_data[SAMPLE_WIDTH-1], rd_data};
		absd = diff[DW-1] ? (~diff + DW'(1)) : diff;
		over = MW'(absd) > MW'(noise_threshold);
	end

	assign down_ready = !valid_q || out_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (down_ready) begin
			valid_q <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (down_ready && ctl_s1.valid) begin
			compared_q <= ctl_s1.cmp;
			changed_q  <= ctl_s1.cmp && over;
		end
	end

	assign out_valid = valid_q;
	assign changed   = changed_q;
	assign compared  = compared_q;

endmodule
